@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swhd_chk: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swhd_chk: next-cycle check failed");

`endif

@@ rtl/core/swhd_pkg.sv @@
// shared types, constants and saturation helper for the stereo widener
package swhd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WG_W        = 11;
    localparam int SG_W        = 9;
    localparam int DS_W        = 12;
    localparam int WG_FRAC     = 8;
    localparam int SG_FRAC     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int WIDE_W      = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GAIN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SURROUND_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = CFG_IDX_W'(2);

    // register reset values
    localparam logic [WG_W-1:0] WG_RESET = WG_W'(256);
    localparam logic [SG_W-1:0] SG_RESET = SG_W'(0);
    localparam logic [DS_W-1:0] DS_RESET = DS_W'(0);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [WIDE_W-1:0]      t_wide;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
        logic    frame_last;
    } t_in_item;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
        logic    frame_last_out;
    } t_out_item;

    localparam t_wide SAT_HI = (t_wide'(1) <<< (SAMPLE_BITS - 1)) - t_wide'(1);
    localparam t_wide SAT_LO = ~SAT_HI;

    // clamp a wide signed value to the sample range
    function automatic t_sample sat_sample(input t_wide x);
        t_sample y;
        if (x > SAT_HI) begin
            y = t_sample'(SAT_HI);
        end else if (x < SAT_LO) begin
            y = t_sample'(SAT_LO);
        end else begin
            y = t_sample'(x);
        end
        return y;
    endfunction

endpackage

@@ rtl/core/swhd_widen.sv @@
// mid/side widening of one stereo pair
module swhd_widen (
    input  swhd_pkg::t_sample         i_left,
    input  swhd_pkg::t_sample         i_right,
    input  logic [swhd_pkg::WG_W-1:0] i_gain,
    output swhd_pkg::t_sample         o_left,
    output swhd_pkg::t_sample         o_right
);
    import swhd_pkg::*;

    logic signed [SAMPLE_BITS:0]        sum;
    logic signed [SAMPLE_BITS:0]        dif;
    logic signed [WG_W:0]               gain_s;
    logic signed [SAMPLE_BITS+WG_W+1:0] side;
    t_wide                              mid_w;
    t_wide                              left_w;
    t_wide                              right_w;

    // sum and difference of the pair
    assign sum    = (SAMPLE_BITS + 1)'(i_left) + (SAMPLE_BITS + 1)'(i_right);
    assign dif    = (SAMPLE_BITS + 1)'(i_left) - (SAMPLE_BITS + 1)'(i_right);
    assign gain_s = signed'({1'b0, i_gain});

    // side scaled by the width gain, mid brought to the same fraction
    assign side  = dif * gain_s;
    assign mid_w = t_wide'(sum) <<< WG_FRAC;

    // halve (mid is l+r) and drop the gain fraction, rounding down
    assign left_w  = (mid_w + t_wide'(side)) >>> (WG_FRAC + 1);
    assign right_w = (mid_w - t_wide'(side)) >>> (WG_FRAC + 1);

    assign o_left  = sat_sample(left_w);
    assign o_right = sat_sample(right_w);

endmodule

@@ rtl/core/swhd_mix.sv @@
// surround mix of the delayed sample, or delayed-right output
module swhd_mix (
    input  swhd_pkg::t_sample         i_left,
    input  swhd_pkg::t_sample         i_right,
    input  swhd_pkg::t_sample         i_delayed,
    input  logic [swhd_pkg::SG_W-1:0] i_gain,
    output swhd_pkg::t_sample         o_left,
    output swhd_pkg::t_sample         o_right
);
    import swhd_pkg::*;

    logic signed [SG_W:0]             gain_s;
    logic signed [SAMPLE_BITS+SG_W:0] prod;
    t_wide                            sur;

    // delayed sample times surround gain, fraction dropped
    assign gain_s = signed'({1'b0, i_gain});
    assign prod   = i_delayed * gain_s;
    assign sur    = t_wide'(prod) >>> SG_FRAC;

    // zero gain selects delayed-right mode
    always_comb begin
        if (i_gain != '0) begin
            o_left  = sat_sample(t_wide'(i_left) + sur);
            o_right = sat_sample(t_wide'(i_right) - sur);
        end else begin
            o_left  = i_left;
            o_right = i_delayed;
        end
    end

endmodule

@@ rtl/core/swhd_dmod.sv @@
// delay register with reduction modulo the ring depth
module swhd_dmod #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [swhd_pkg::DS_W-1:0]     i_value,
    output logic                          o_busy,
    output logic [$clog2(RING_DEPTH)-1:0] o_delay
);
    import swhd_pkg::*;

    localparam int     PTR_W   = $clog2(RING_DEPTH);
    localparam int     RSHIFT  = DS_W + $clog2(RING_DEPTH);
    localparam int     RECIP_W = DS_W + 2;
    localparam int     PROD_W  = DS_W + RECIP_W;
    localparam longint RECIP_L = ((64'sd1 <<< RSHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
    localparam logic [DS_W-1:0]    DEPTH_LO = DS_W'(RING_DEPTH);

    logic [DS_W-1:0]   r_val;
    logic [DS_W-1:0]   r_q;
    logic [DS_W-1:0]   r_rem;
    logic              r_busy;
    logic              r_second;
    logic [PROD_W-1:0] q_prod;
    logic [DS_W-1:0]   q_calc;
    logic [DS_W-1:0]   q_times_d;

    // quotient by reciprocal multiplication, exact over the whole delay range
    assign q_prod    = PROD_W'(r_val) * PROD_W'(RECIP);
    assign q_calc    = DS_W'(q_prod >> RSHIFT);
    assign q_times_d = r_q * DEPTH_LO;

    // quotient registered first, then the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val    <= DS_RESET;
            r_q      <= '0;
            r_rem    <= DS_RESET;
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (i_load) begin
            r_val    <= i_value;
            r_busy   <= 1'b1;
            r_second <= 1'b0;
        end else if (r_busy) begin
            if (!r_second) begin
                r_q      <= q_calc;
                r_second <= 1'b1;
            end else begin
                r_rem    <= r_val - q_times_d;
                r_busy   <= 1'b0;
                r_second <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_delay = PTR_W'(r_rem);

endmodule

@@ rtl/core/swhd_ring.sv @@
// delay ring memory, one write and one registered read port
module swhd_ring #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  swhd_pkg::t_sample        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output swhd_pkg::t_sample        o_rdata
);
    import swhd_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while the reader stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/stereo_widener_haas_delay.sv @@
// stereo widener with haas delay ring: top level
// an input pair passes the input, widen, ring read and output registers in that order before its result is valid
// throughput: one stereo pair per cycle while neither an output stall nor a delay reduction holds the input
// a delay_samples write stalls input while the delay is reduced modulo the depth
// reset is synchronous active low; ring contents are not cleared, a fill count
// makes entries never written since reset read as zero, so no clearing pass is run
module stereo_widener_haas_delay #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  swhd_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output swhd_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swhd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swhd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import swhd_pkg::*;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]    DEPTH_X   = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

    // configuration
    logic [WG_W-1:0]  r_wg;
    logic [SG_W-1:0]  r_sg;
    logic             cfg_wr;
    logic             dly_load;
    logic             dly_busy;
    logic [PTR_W-1:0] dly;

    // pipeline
    logic                     r_a_v;
    t_in_item                 r_a;
    logic                     r_b_v;
    t_sample                  r_b_wl;
    t_sample                  r_b_wr;
    logic                     r_b_last;
    logic                     r_c_v;
    t_sample                  r_c_wl;
    t_sample                  r_c_wr;
    logic                     r_c_last;
    logic                     r_c_use_mem;
    t_sample                  r_c_alt;
    logic                     r_o_v;
    t_out_item                r_o;
    logic                     adv_a;
    logic                     adv_b;
    logic                     adv_c;
    logic                     adv_o;
    logic                     in_acc;

    // ring addressing
    logic [PTR_W-1:0]         r_wp;
    logic [FILL_W-1:0]        r_fill;
    logic [PTR_W:0]           rd_diff;
    logic [PTR_W-1:0]         rd_addr;
    logic                     rd_hit;
    logic                     rd_written;
    logic                     ring_we;
    logic signed [SAMPLE_BITS:0] pair_sum;
    t_sample                  store;
    t_sample                  ring_q;
    t_sample                  delayed;

    // datapath results
    t_sample                  wid_l;
    t_sample                  wid_r;
    t_sample                  mix_l;
    t_sample                  mix_r;

    // configuration transfers
    assign o_cfg_ready = !dly_busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign dly_load    = cfg_wr && (i_cfg_index == REG_DELAY_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wg <= WG_RESET;
            r_sg <= SG_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_WIDTH_GAIN:    r_wg <= i_cfg_data[WG_W-1:0];
                REG_SURROUND_GAIN: r_sg <= i_cfg_data[SG_W-1:0];
                default: ;
            endcase
        end
    end

    swhd_dmod #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dly_load),
        .i_value (i_cfg_data[DS_W-1:0]),
        .o_busy  (dly_busy),
        .o_delay (dly)
    );

    // stage advance, a stage moves when the next one is empty or moving
    assign adv_o      = !r_o_v || !i_out_stall;
    assign adv_c      = !r_c_v || adv_o;
    assign adv_b      = !r_b_v || adv_c;
    assign adv_a      = !r_a_v || adv_b;
    assign o_in_stall = !adv_a || dly_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv_a) begin
            r_a_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a <= i_in_data;
        end
    end

    // widening
    swhd_widen u_widen (
        .i_left  (r_a.left_in),
        .i_right (r_a.right_in),
        .i_gain  (r_wg),
        .o_left  (wid_l),
        .o_right (wid_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b && r_a_v) begin
            r_b_wl   <= wid_l;
            r_b_wr   <= wid_r;
            r_b_last <= r_a.frame_last;
        end
    end

    // value stored in the ring: mid in surround mode, widened right otherwise
    assign pair_sum = (SAMPLE_BITS + 1)'(r_b_wl) + (SAMPLE_BITS + 1)'(r_b_wr);
    assign store    = (r_sg != '0) ? t_sample'(pair_sum[SAMPLE_BITS:1]) : r_b_wr;

    // read address trails the write pointer by the delay
    assign rd_diff    = {1'b0, r_wp} - {1'b0, dly};
    assign rd_addr    = rd_diff[PTR_W] ? PTR_W'(rd_diff + DEPTH_X) : rd_diff[PTR_W-1:0];
    assign rd_hit     = rd_addr == r_wp;
    assign rd_written = FILL_W'(rd_addr) < r_fill;
    assign ring_we    = r_b_v && adv_c;

    // write pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (ring_we) begin
            r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    swhd_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (store),
        .i_re    (adv_c),
        .i_raddr (rd_addr),
        .o_rdata (ring_q)
    );

    // ring read stage, with bypass for zero delay and unwritten entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_c && r_b_v) begin
            r_c_wl      <= r_b_wl;
            r_c_wr      <= r_b_wr;
            r_c_last    <= r_b_last;
            r_c_use_mem <= !rd_hit && rd_written;
            r_c_alt     <= rd_hit ? store : '0;
        end
    end

    assign delayed = r_c_use_mem ? ring_q : r_c_alt;

    // surround mix
    swhd_mix u_mix (
        .i_left    (r_c_wl),
        .i_right   (r_c_wr),
        .i_delayed (delayed),
        .i_gain    (r_sg),
        .o_left    (mix_l),
        .o_right   (mix_r)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv_o) begin
            r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_c_v) begin
            r_o.left_out       <= mix_l;
            r_o.right_out      <= mix_r;
            r_o.frame_last_out <= r_c_last;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o;

endmodule

@@ rtl/core/swhd_chk.sv @@
// port checker for the stereo widener, bound to the top level
`include "assert_macros.svh"

module swhd_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input swhd_pkg::t_out_item             o_out_data,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [swhd_pkg::CFG_IDX_W-1:0]  i_cfg_index
);
    import swhd_pkg::*;

    // a stalled result holds its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // a delay write starts the reduction: input and config both blocked next cycle
    `ASSERT_NEXT(a_dly_block, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && i_cfg_index == REG_DELAY_SAMPLES, o_in_stall && !o_cfg_ready)

    // while the config port is busy no input transfer is taken
    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, !o_cfg_ready, o_in_stall)

    // pipeline is empty after reset, nothing comes out before the latency
    `ASSERT_IMPL(a_rst_quiet, i_clk, i_rst_n, $rose(i_rst_n), !o_out_valid ##1 !o_out_valid ##1 !o_out_valid)

endmodule

bind stereo_widener_haas_delay swhd_chk u_chk (.*);

@@ tb/tb_stereo_widener_haas_delay.sv @@
// self-checking testbench for the stereo widener with haas delay ring
`timescale 1ns / 1ps

module tb_stereo_widener_haas_delay;
    import swhd_pkg::*;

    localparam int     RING_SIZE   = 4096;
    localparam longint SAMPLE_MAX  = 64'sd8388607;
    localparam longint SAMPLE_MIN  = -64'sd8388608;
    localparam int     RANDOM_ITEMS = 1300;
    localparam int     DRAIN_CYCLES = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    // predicts each processed pair and holds the pairs still to come out
    class widener_scoreboard;
        longint     ring_mem [RING_SIZE];
        bit [11:0]  wr_ptr;
        bit [10:0]  width_gain;
        bit [8:0]   surround_gain;
        bit [11:0]  delay_len;
        t_out_item  pending_q [$];
        int         fail_count;

        function new();
            foreach (ring_mem[i]) ring_mem[i] = 0;
            wr_ptr        = '0;
            width_gain    = WG_RESET;
            surround_gain = SG_RESET;
            delay_len     = DS_RESET;
            fail_count    = 0;
        endfunction

        function longint clamp_sample(longint x);
            if (x > SAMPLE_MAX) return SAMPLE_MAX;
            if (x < SAMPLE_MIN) return SAMPLE_MIN;
            return x;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH_GAIN:    width_gain    = data[10:0];
                REG_SURROUND_GAIN: surround_gain = data[8:0];
                REG_DELAY_SAMPLES: delay_len     = data[11:0];
                default: ;
            endcase
        endfunction

        // widen, then either mix the delayed mid back in or delay the right channel
        function void note_input(t_in_item it);
            longint     l, r, s, d, wl, wr, tap, lo, ro;
            bit [11:0]  rd;
            t_out_item  want;
            l  = longint'($signed(it.left_in));
            r  = longint'($signed(it.right_in));
            s  = l + r;
            d  = l - r;
            wl = clamp_sample((256 * s + longint'(width_gain) * d) >>> 9);
            wr = clamp_sample((256 * s - longint'(width_gain) * d) >>> 9);
            rd = wr_ptr - delay_len;
            if (surround_gain != 0) begin
                ring_mem[wr_ptr] = clamp_sample((wl + wr) >>> 1);
                tap = (ring_mem[rd] * longint'(surround_gain)) >>> 8;
                lo  = clamp_sample(wl + tap);
                ro  = clamp_sample(wr - tap);
            end else begin
                ring_mem[wr_ptr] = wr;
                lo = wl;
                ro = ring_mem[rd];
            end
            wr_ptr = wr_ptr + 12'd1;
            want.left_out       = t_sample'(lo);
            want.right_out      = t_sample'(ro);
            want.frame_last_out = it.frame_last;
            pending_q.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: left %0d right %0d last %0b",
                             got.left_out, got.right_out, got.frame_last_out);
                return;
            end
            want = pending_q.pop_front();
            if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
                got.frame_last_out !== want.frame_last_out) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: exp %0d %0d %0b, got %0d %0d %0b",
                             want.left_out, want.right_out, want.frame_last_out,
                             got.left_out, got.right_out, got.frame_last_out);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_item                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out_item               o_out_data;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    widener_scoreboard sb = new();
    bit                idle_on = 1'b1;

    stereo_widener_haas_delay DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // random back-pressure on the result side
    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 12);
    end

    // watch every transfer on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready === 1'b1)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_stall === 1'b0)
                sb.note_input(i_in_data);
            if (o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // offer one pair, with random idle cycles ahead of it
    task automatic send_pair(t_sample l, t_sample r, bit last);
        while (idle_on && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_data.left_in    <= l;
        i_in_data.right_in   <= r;
        i_in_data.frame_last <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // hold off the sender until every pair has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // one register transfer; valid is lowered by the caller after the batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic configure(int wg, int sg, int ds);
        write_reg(REG_WIDTH_GAIN, CFG_DATA_W'(wg));
        write_reg(REG_SURROUND_GAIN, CFG_DATA_W'(sg));
        write_reg(REG_DELAY_SAMPLES, CFG_DATA_W'(ds));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(7))
            0:       return t_sample'(SAMPLE_MAX);
            1:       return t_sample'(SAMPLE_MIN);
            2:       return t_sample'(int'($urandom_range(8191)) - 4096);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // settings per phase: mostly fixed corner settings on phases 0 to 3 of every six, random ones otherwise
    task automatic configure_phase(int phase);
        int wg, sg, ds;
        wg = $urandom_range(4095);
        sg = ($urandom_range(1) == 0) ? 0 : $urandom_range(4095);
        ds = ($urandom_range(1) == 0) ? $urandom_range(64) : $urandom_range(4095);
        case (phase % 6)
            0: begin wg = 2047; sg = 511; ds = 0;    end
            1: begin wg = 0;    sg = 256; ds = 4095; end
            2: begin wg = 1024; sg = 0;   ds = 1;    end
            3: begin wg = 256;  sg = $urandom_range(1, 255); end
            default: ;
        endcase
        if (phase == 0)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        configure(wg, sg, ds);
    endtask

    // main sequence
    initial begin
        int total, phase, n;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: unity width, delayed right with zero delay
        send_pair('0, '0, 1'b0);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), 1'b1);
        send_pair(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MIN), 1'b0);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b1);
        send_pair(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MAX), 1'b0);
        wait_for_results();

        // full width, full surround, zero delay returns the mid just stored
        configure(1024, 256, 0);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b0);
        send_pair(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MAX), 1'b1);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), 1'b0);
        send_pair(t_sample'(1), t_sample'(-1), 1'b1);
        send_pair(t_sample'(-1), t_sample'(1), 1'b0);
        wait_for_results();

        // gains past their nominal range saturate the outputs
        configure(2047, 511, 1);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b0);
        send_pair(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MAX), 1'b1);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX), 1'b0);
        send_pair(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MIN), 1'b1);
        wait_for_results();

        // mono collapse with the longest delay
        configure(0, 0, 4095);
        send_pair(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), 1'b1);
        send_pair(t_sample'(12345), t_sample'(-54321), 1'b0);
        send_pair(t_sample'(SAMPLE_MIN), t_sample'(7), 1'b1);
        wait_for_results();

        // random phases, one of them without any idling
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            configure_phase(phase);
            idle_on = (phase != 4);
            n = $urandom_range(40, 110);
            for (int k = 0; k < n; k++) begin
                send_pair(rand_sample(), rand_sample(), 1'($urandom_range(1)));
                if (phase == 2 && k == n / 2)
                    wait_for_results();
            end
            wait_for_results();
            total += n;
            phase++;
        end
        idle_on = 1'b1;

        wait_for_results();
        if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
